// ----- sv/mini_mips8_instruction_execute_defines.svh -----
// Assertion macros used by the top-level RTL file. Both expect clk and rst_n in scope.
`ifndef MINI_MIPS8_INSTRUCTION_EXECUTE_DEFINES_SVH
`define MINI_MIPS8_INSTRUCTION_EXECUTE_DEFINES_SVH

// Same-cycle implication.
`define MM8_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mm8 check failed");

// Next-cycle implication.
`define MM8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mm8 check failed");

`endif

// ----- sv/mm8_pkg.sv -----
package mm8_pkg;

  // Data memory depth, a power of two from 16 to 256.
  localparam int DataDepth = 256;
  localparam int MemAw     = $clog2(DataDepth);

  typedef enum logic [1:0] {
    HOST_EXEC   = 2'd0,
    HOST_MEM_WR = 2'd1,
    HOST_MEM_RD = 2'd2,
    HOST_REG_RD = 2'd3
  } host_op_t;

  localparam logic [3:0] OPC_RTYPE = 4'd0;
  localparam logic [3:0] OPC_JUMP  = 4'd2;
  localparam logic [3:0] OPC_ADDI  = 4'd4;
  localparam logic [3:0] OPC_BEQ   = 4'd8;
  localparam logic [3:0] OPC_LW    = 4'd11;
  localparam logic [3:0] OPC_SW    = 4'd15;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  // Outcome of the execute stage for one item.
  typedef struct packed {
    logic [7:0]       next_pc;
    logic             reg_wr;
    logic [2:0]       dest;
    logic [7:0]       value;
    logic             load;          // value comes from the data memory read
    logic             mem_wr;
    logic [MemAw-1:0] mem_addr;
    logic [7:0]       mem_wdata;
    logic             mem_to_rdata;  // host read of the data memory
    logic             ovf;
    logic [7:0]       rdata;
  } exe_res_t;

  function automatic logic [MemAw-1:0] mem_index(input logic [7:0] addr);
    mem_index = addr[MemAw-1:0];
  endfunction

endpackage

// ----- sv/mm8_exe.sv -----
module mm8_exe (
  input  mm8_pkg::host_op_t host_op,
  input  logic [15:0]       instr,
  input  logic [7:0]        host_addr,
  input  logic [7:0]        host_data,
  input  logic [7:0]        pc,
  input  logic [7:0]        src_a,
  input  logic [7:0]        src_b,
  output mm8_pkg::exe_res_t res
);

  logic [3:0] opc;
  logic [2:0] rt;
  logic [2:0] rd;
  logic [2:0] funct;
  logic [8:0] simm;
  logic [8:0] a9;
  logic [8:0] b9;
  logic [8:0] sum_ab;
  logic [8:0] diff_ab;
  logic [8:0] sum_ai;
  logic [8:0] r_val;
  logic       r_chk;

  assign opc     = instr[15:12];
  assign rt      = instr[8:6];
  assign rd      = instr[5:3];
  assign funct   = instr[2:0];
  assign simm    = {{3{instr[5]}}, instr[5:0]};
  assign a9      = {src_a[7], src_a};
  assign b9      = {src_b[7], src_b};
  assign sum_ab  = a9 + b9;
  assign diff_ab = a9 - b9;
  assign sum_ai  = a9 + simm;

  always_comb begin
    r_chk = 1'b0;
    case (funct)
      mm8_pkg::FN_ADD: begin
        r_val = sum_ab;
        r_chk = 1'b1;
      end
      mm8_pkg::FN_SUB: begin
        r_val = diff_ab;
        r_chk = 1'b1;
      end
      mm8_pkg::FN_AND: r_val = {1'b0, src_a & src_b};
      mm8_pkg::FN_OR:  r_val = {1'b0, src_a | src_b};
      default:         r_val = 9'd0;
    endcase
  end

  always_comb begin
    res              = '0;
    res.next_pc      = pc;
    res.mem_addr     = mm8_pkg::mem_index(host_addr);
    res.mem_wdata    = host_data;
    case (host_op)
      mm8_pkg::HOST_MEM_WR: res.mem_wr = 1'b1;
      mm8_pkg::HOST_MEM_RD: res.mem_to_rdata = 1'b1;
      mm8_pkg::HOST_REG_RD: res.rdata = src_a;
      mm8_pkg::HOST_EXEC: begin
        res.next_pc = pc + 8'd1;
        case (opc)
          mm8_pkg::OPC_RTYPE: begin
            if (r_chk && (r_val[8] ^ r_val[7])) begin
              res.ovf = 1'b1;
            end else begin
              res.reg_wr = 1'b1;
              res.dest   = rd;
              res.value  = r_val[7:0];
            end
          end
          mm8_pkg::OPC_ADDI: begin
            if (sum_ai[8] ^ sum_ai[7]) begin
              res.ovf = 1'b1;
            end else begin
              res.reg_wr = 1'b1;
              res.dest   = rt;
              res.value  = sum_ai[7:0];
            end
          end
          mm8_pkg::OPC_LW: begin
            if (sum_ai[8] ^ sum_ai[7]) begin
              res.ovf = 1'b1;
            end else begin
              res.reg_wr   = 1'b1;
              res.dest     = rt;
              res.load     = 1'b1;
              res.mem_addr = mm8_pkg::mem_index(sum_ai[7:0]);
            end
          end
          mm8_pkg::OPC_SW: begin
            if (sum_ai[8] ^ sum_ai[7]) begin
              res.ovf = 1'b1;
            end else begin
              res.mem_wr    = 1'b1;
              res.mem_addr  = mm8_pkg::mem_index(sum_ai[7:0]);
              res.mem_wdata = src_b;
            end
          end
          mm8_pkg::OPC_BEQ: begin
            if (diff_ab[8] ^ diff_ab[7]) begin
              res.ovf = 1'b1;
            end else if (diff_ab == 9'd0) begin
              res.next_pc = pc + 8'd1 + simm[7:0];
            end
          end
          mm8_pkg::OPC_JUMP: res.next_pc = instr[7:0];
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/mini_mips8_instruction_execute.sv -----
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   op, instr_word, host_addr, host_data
// out_     output     out_valid / out_ready next_pc, reg_write_done, reg_dest,
//                                           reg_value, mem_write_done,
//                                           alu_overflow, read_data
//
// One item per cycle sustained while out_ready stays high; a result passes the read, memory and result registers.
// Stages: register file read (registered), execute plus data memory access, result register.
// The data memory port makes one access per cycle as an item leaves execute: a read, plus a write for a store.
// Reset clears the PC and the valid bits of both memories at once; no clearing pass.
// A stalled output holds every stage behind it; in_ready drops only when all stages are full.
`include "mini_mips8_instruction_execute_defines.svh"

module mini_mips8_instruction_execute (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [15:0]       in_instr_word,
  input  logic [7:0]        in_host_addr,
  input  logic signed [7:0] in_host_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_next_pc,
  output logic              out_reg_write_done,
  output logic [2:0]        out_reg_dest,
  output logic signed [7:0] out_reg_value,
  output logic              out_mem_write_done,
  output logic              out_alu_overflow,
  output logic signed [7:0] out_read_data
);

  // Register file and data memory.
  logic [7:0]                   rf_ram_r [8];
  logic [7:0]                   rf_vld_r;
  logic [7:0]                   dm_ram_r [mm8_pkg::DataDepth];
  logic [mm8_pkg::DataDepth-1:0] dm_vld_r;

  // Read stage.
  logic              s1_v_r, s1_v_nxt;
  mm8_pkg::host_op_t s1_op_r;
  logic [15:0]       s1_instr_r;
  logic [7:0]        s1_haddr_r;
  logic [7:0]        s1_hdata_r;
  logic [2:0]        s1_ia_r, s1_ib_r;
  logic [7:0]        rf_qa_r, rf_qb_r;
  logic [7:0]        pc_r;

  // Memory stage.
  logic              s2_v_r, s2_v_nxt;
  mm8_pkg::exe_res_t s2_res_r;
  logic [7:0]        mem_q_r;

  // Last register write, for forwarding.
  logic              w_v_r;
  logic [2:0]        w_dest_r;
  logic [7:0]        w_val_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_next_pc_r;
  logic              out_reg_write_r;
  logic [2:0]        out_reg_dest_r;
  logic [7:0]        out_reg_value_r;
  logic              out_mem_write_r;
  logic              out_ovf_r;
  logic [7:0]        out_rdata_r;

  logic              in_acc, s1_adv, s2_adv;
  mm8_pkg::host_op_t in_op_e;
  logic [2:0]        in_ia, in_ib;
  logic [7:0]        src_a, src_b;
  logic [7:0]        s2_val, s2_rdata;
  mm8_pkg::exe_res_t exe_res;

  assign s2_adv   = s2_v_r && (!out_valid_r || out_ready);
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign in_op_e = mm8_pkg::host_op_t'(in_op);
  assign in_ia   = (in_op_e == mm8_pkg::HOST_REG_RD) ? in_host_addr[2:0] : in_instr_word[11:9];
  assign in_ib   = in_instr_word[8:6];

  assign s1_v_nxt      = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign s2_v_nxt      = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_r);
  assign out_valid_nxt = s2_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  assign s2_val   = s2_res_r.load ? mem_q_r : s2_res_r.value;
  assign s2_rdata = s2_res_r.mem_to_rdata ? mem_q_r : s2_res_r.rdata;

  // Forward the item in the memory stage first, then the last completed write.
  always_comb begin
    if (s2_v_r && s2_res_r.reg_wr && (s2_res_r.dest == s1_ia_r)) begin
      src_a = s2_val;
    end else if (w_v_r && (w_dest_r == s1_ia_r)) begin
      src_a = w_val_r;
    end else begin
      src_a = rf_qa_r;
    end
    if (s2_v_r && s2_res_r.reg_wr && (s2_res_r.dest == s1_ib_r)) begin
      src_b = s2_val;
    end else if (w_v_r && (w_dest_r == s1_ib_r)) begin
      src_b = w_val_r;
    end else begin
      src_b = rf_qb_r;
    end
  end

  mm8_exe u_exe (
    .host_op   (s1_op_r),
    .instr     (s1_instr_r),
    .host_addr (s1_haddr_r),
    .host_data (s1_hdata_r),
    .pc        (pc_r),
    .src_a     (src_a),
    .src_b     (src_b),
    .res       (exe_res)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      w_v_r       <= 1'b0;
      pc_r        <= 8'd0;
      rf_vld_r    <= '0;
      dm_vld_r    <= '0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        pc_r <= exe_res.next_pc;
        if (exe_res.mem_wr) begin
          dm_vld_r[exe_res.mem_addr] <= 1'b1;
        end
      end
      if (s2_adv && s2_res_r.reg_wr) begin
        rf_vld_r[s2_res_r.dest] <= 1'b1;
        w_v_r                   <= 1'b1;
      end
    end
  end

  // Register file: two read ports at transfer, write as an item leaves the memory stage.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rf_qa_r <= rf_vld_r[in_ia] ? rf_ram_r[in_ia] : 8'd0;
      rf_qb_r <= rf_vld_r[in_ib] ? rf_ram_r[in_ib] : 8'd0;
    end
    if (s2_adv && s2_res_r.reg_wr) begin
      rf_ram_r[s2_res_r.dest] <= s2_val;
      w_dest_r                <= s2_res_r.dest;
      w_val_r                 <= s2_val;
    end
  end

  // Data memory: one access as an item leaves execute.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (exe_res.mem_wr) begin
        dm_ram_r[exe_res.mem_addr] <= exe_res.mem_wdata;
      end
      mem_q_r <= dm_vld_r[exe_res.mem_addr] ? dm_ram_r[exe_res.mem_addr] : 8'd0;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_op_e;
      s1_instr_r <= in_instr_word;
      s1_haddr_r <= in_host_addr;
      s1_hdata_r <= in_host_data;
      s1_ia_r    <= in_ia;
      s1_ib_r    <= in_ib;
    end
    if (s1_adv) begin
      s2_res_r <= exe_res;
    end
    if (s2_adv) begin
      out_next_pc_r   <= s2_res_r.next_pc;
      out_reg_write_r <= s2_res_r.reg_wr;
      out_reg_dest_r  <= s2_res_r.dest;
      out_reg_value_r <= s2_res_r.reg_wr ? s2_val : 8'd0;
      out_mem_write_r <= s2_res_r.mem_wr;
      out_ovf_r       <= s2_res_r.ovf;
      out_rdata_r     <= s2_rdata;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_next_pc        = out_next_pc_r;
  assign out_reg_write_done = out_reg_write_r;
  assign out_reg_dest       = out_reg_dest_r;
  assign out_reg_value      = out_reg_value_r;
  assign out_mem_write_done = out_mem_write_r;
  assign out_alu_overflow   = out_ovf_r;
  assign out_read_data      = out_rdata_r;

  `MM8_ASSERT_IMPL(a_ovf_blocks_writes, out_valid_r && out_ovf_r, !out_reg_write_r && !out_mem_write_r)
  `MM8_ASSERT_IMPL(a_no_write_zero, out_valid_r && !out_reg_write_r, out_reg_dest_r == 3'd0 && out_reg_value_r == 8'd0)
  `MM8_ASSERT_NEXT(a_host_keeps_pc, s1_adv && s1_op_r != mm8_pkg::HOST_EXEC, pc_r == $past(pc_r))
  `MM8_ASSERT_NEXT(a_fwd_tracks_write, s2_adv && s2_res_r.reg_wr, w_v_r && w_dest_r == $past(s2_res_r.dest))

endmodule

// ----- tb/mini_mips8_instruction_execute_tb.sv -----
module mini_mips8_instruction_execute_tb;

  localparam logic [3:0] OPC_SPARE  = 4'hE;
  localparam logic [2:0] FN_SPARE   = 3'd7;
  localparam int         PhaseItems = 458;
  localparam int         StallLimit = 4000;
  localparam int         DrainCycles = 10;

  typedef struct packed {
    mm8_pkg::host_op_t op;
    logic [15:0]       instr;
    logic [7:0]        addr;
    logic [7:0]        data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       reg_wr;
    logic [2:0] dest;
    logic [7:0] value;
    logic       mem_wr;
    logic       ovf;
    logic [7:0] rdata;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_op = '0;
  logic [15:0]       in_instr_word = '0;
  logic [7:0]        in_host_addr = '0;
  logic signed [7:0] in_host_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_next_pc;
  logic              out_reg_write_done;
  logic [2:0]        out_reg_dest;
  logic signed [7:0] out_reg_value;
  logic              out_mem_write_done;
  logic              out_alu_overflow;
  logic signed [7:0] out_read_data;

  cmd_t     pending_cmds[$];
  outcome_t expected_outcomes[$];
  cmd_t     cur_cmd;
  outcome_t pred_outcome;
  outcome_t want_outcome;
  outcome_t got_outcome;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       mismatch_count = 0;
  int       idle_cycles = 0;

  // Architectural state as the core should see it.
  logic [7:0] pc_model;
  logic [7:0] regs_model [8];
  logic [7:0] dmem_model [mm8_pkg::DataDepth];

  mini_mips8_instruction_execute i_dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit out_of_range(int v);
    return v > 127 || v < -128;
  endfunction

  task automatic execute_cmd(input cmd_t c, output outcome_t o);
    logic [3:0] opc;
    logic [2:0] rs, rt, rd, fn;
    int         a, b, simm, r, target;
    logic [7:0] low;
    o = '0;
    o.next_pc = pc_model;
    case (c.op)
      mm8_pkg::HOST_MEM_WR: begin
        dmem_model[c.addr % mm8_pkg::DataDepth] = c.data;
        o.mem_wr = 1'b1;
      end
      mm8_pkg::HOST_MEM_RD: o.rdata = dmem_model[c.addr % mm8_pkg::DataDepth];
      mm8_pkg::HOST_REG_RD: o.rdata = regs_model[c.addr[2:0]];
      default: begin
        {opc, rs, rt, rd, fn} = c.instr;
        a = $signed(regs_model[rs]);
        b = $signed(regs_model[rt]);
        simm = $signed(c.instr[5:0]);
        r = 0;
        o.next_pc = pc_model + 8'd1;
        case (opc)
          mm8_pkg::OPC_RTYPE: begin
            if (fn == mm8_pkg::FN_ADD) r = a + b;
            else if (fn == mm8_pkg::FN_SUB) r = a - b;
            else if (fn == mm8_pkg::FN_AND) r = regs_model[rs] & regs_model[rt];
            else if (fn == mm8_pkg::FN_OR) r = regs_model[rs] | regs_model[rt];
            if ((fn == mm8_pkg::FN_ADD || fn == mm8_pkg::FN_SUB) && out_of_range(r)) begin
              o.ovf = 1'b1;
            end else begin
              o.reg_wr = 1'b1;
              o.dest = rd;
              o.value = r[7:0];
            end
          end
          mm8_pkg::OPC_ADDI, mm8_pkg::OPC_LW, mm8_pkg::OPC_SW: begin
            r = a + simm;
            low = r[7:0];
            if (out_of_range(r)) begin
              o.ovf = 1'b1;
            end else if (opc == mm8_pkg::OPC_SW) begin
              dmem_model[low % mm8_pkg::DataDepth] = regs_model[rt];
              o.mem_wr = 1'b1;
            end else begin
              o.reg_wr = 1'b1;
              o.dest = rt;
              o.value = (opc == mm8_pkg::OPC_LW) ? dmem_model[low % mm8_pkg::DataDepth] : low;
            end
          end
          mm8_pkg::OPC_BEQ: begin
            r = a - b;
            if (out_of_range(r)) begin
              o.ovf = 1'b1;
            end else if (r == 0) begin
              target = pc_model + 1 + simm;
              o.next_pc = target[7:0];
            end
          end
          mm8_pkg::OPC_JUMP: o.next_pc = c.instr[7:0];
          default: ;
        endcase
        if (o.reg_wr) regs_model[o.dest] = o.value;
        pc_model = o.next_pc;
      end
    endcase
  endtask

  function automatic cmd_t exec_cmd(logic [15:0] w);
    cmd_t c;
    c.op = mm8_pkg::HOST_EXEC;
    c.instr = w;
    c.addr = 8'($urandom);
    c.data = 8'($urandom);
    return c;
  endfunction

  function automatic cmd_t host_cmd(mm8_pkg::host_op_t op, logic [7:0] addr,
                                    logic [7:0] data);
    cmd_t c;
    c.op = op;
    c.instr = 16'($urandom);
    c.addr = addr;
    c.data = data;
    return c;
  endfunction

  function automatic logic [15:0] rtype(logic [2:0] rs, logic [2:0] rt, logic [2:0] rd,
                                       logic [2:0] fn);
    return {mm8_pkg::OPC_RTYPE, rs, rt, rd, fn};
  endfunction

  function automatic logic [15:0] itype(logic [3:0] opc, logic [2:0] rs, logic [2:0] rt,
                                       logic [5:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  // Mostly known opcodes with random fields; host writes seed memory with wide values
  // so loads bring operands that overflow.
  function automatic cmd_t rand_cmd();
    logic [15:0] w;
    int          pick;
    pick = $urandom_range(0, 99);
    w = 16'($urandom);
    if (pick < 12) return host_cmd(mm8_pkg::HOST_MEM_WR, 8'($urandom), 8'($urandom));
    if (pick < 20) return host_cmd(mm8_pkg::HOST_MEM_RD, 8'($urandom), 8'($urandom));
    if (pick < 28) return host_cmd(mm8_pkg::HOST_REG_RD, 8'($urandom), 8'($urandom));
    case ($urandom_range(0, 9))
      0, 1, 2: w[15:12] = mm8_pkg::OPC_RTYPE;
      3: w[15:12] = mm8_pkg::OPC_ADDI;
      4, 5: w[15:12] = mm8_pkg::OPC_LW;
      6: w[15:12] = mm8_pkg::OPC_SW;
      7: begin
        w[15:12] = mm8_pkg::OPC_BEQ;
        if ($urandom_range(0, 2) == 0) w[8:6] = w[11:9];
      end
      8: w[15:12] = mm8_pkg::OPC_JUMP;
      default: ;
    endcase
    return exec_cmd(w);
  endfunction

  task automatic report_mismatch(string what, outcome_t want, outcome_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected pc=%0d wr=%0b dest=%0d val=%0d memw=%0b ovf=%0b rd=%0d",
               what, want.next_pc, want.reg_wr, want.dest, $signed(want.value),
               want.mem_wr, want.ovf, $signed(want.rdata));
      $display("  actual pc=%0d wr=%0b dest=%0d val=%0d memw=%0b ovf=%0b rd=%0d",
               got.next_pc, got.reg_wr, got.dest, $signed(got.value),
               got.mem_wr, got.ovf, $signed(got.rdata));
    end
  endtask

  // Driver: predict on every input transfer, then refill or hold the channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      pc_model = '0;
      foreach (regs_model[i]) regs_model[i] = '0;
      foreach (dmem_model[i]) dmem_model[i] = '0;
    end else begin
      if (in_valid && in_ready) begin
        execute_cmd(cur_cmd, pred_outcome);
        expected_outcomes.push_back(pred_outcome);
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_op <= cur_cmd.op;
          in_instr_word <= cur_cmd.instr;
          in_host_addr <= cur_cmd.addr;
          in_host_data <= cur_cmd.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output transfer against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_outcome = {out_next_pc, out_reg_write_done, out_reg_dest, out_reg_value,
                       out_mem_write_done, out_alu_overflow, out_read_data};
        if (expected_outcomes.size() == 0) begin
          report_mismatch("unexpected result", '0, got_outcome);
        end else begin
          want_outcome = expected_outcomes.pop_front();
          if (got_outcome !== want_outcome)
            report_mismatch("result mismatch", want_outcome, got_outcome);
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles with work outstanding and no transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else if (in_valid || pending_cmds.size() > 0 || expected_outcomes.size() > 0) begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: boundary data, every operation, overflow on the add, subtract, addi, store
    // and branch paths, branch wrap, jump ignoring overflow, unknown opcode, PC wrap.
    pending_cmds.push_back(host_cmd(mm8_pkg::HOST_REG_RD, 8'hFF, 8'h00));
    pending_cmds.push_back(host_cmd(mm8_pkg::HOST_MEM_WR, 8'hFF, 8'h80));
    pending_cmds.push_back(host_cmd(mm8_pkg::HOST_MEM_WR, 8'h00, 8'h7F));
    pending_cmds.push_back(host_cmd(mm8_pkg::HOST_MEM_RD, 8'hFF, 8'h00));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_LW, 3'd0, 3'd1, 6'h3F)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_LW, 3'd0, 3'd2, 6'h00)));
    pending_cmds.push_back(exec_cmd(rtype(3'd2, 3'd2, 3'd3, mm8_pkg::FN_ADD)));
    pending_cmds.push_back(exec_cmd(rtype(3'd1, 3'd2, 3'd3, mm8_pkg::FN_SUB)));
    pending_cmds.push_back(exec_cmd(rtype(3'd2, 3'd1, 3'd4, mm8_pkg::FN_SUB)));
    pending_cmds.push_back(exec_cmd(rtype(3'd1, 3'd2, 3'd4, mm8_pkg::FN_ADD)));
    pending_cmds.push_back(exec_cmd(rtype(3'd1, 3'd4, 3'd5, mm8_pkg::FN_AND)));
    pending_cmds.push_back(exec_cmd(rtype(3'd1, 3'd2, 3'd6, mm8_pkg::FN_OR)));
    pending_cmds.push_back(exec_cmd(rtype(3'd2, 3'd2, 3'd7, FN_SPARE)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_ADDI, 3'd2, 3'd0, 6'h1F)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_ADDI, 3'd1, 3'd0, 6'h20)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_ADDI, 3'd0, 3'd0, 6'h1F)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_SW, 3'd1, 3'd2, 6'h00)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_SW, 3'd1, 3'd2, 6'h3F)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_LW, 3'd1, 3'd3, 6'h00)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_BEQ, 3'd0, 3'd0, 6'h20)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_BEQ, 3'd1, 3'd2, 6'h01)));
    pending_cmds.push_back(exec_cmd(itype(mm8_pkg::OPC_BEQ, 3'd0, 3'd2, 6'h05)));
    pending_cmds.push_back(exec_cmd({mm8_pkg::OPC_JUMP, 3'd1, 1'b0, 8'hFF}));
    pending_cmds.push_back(exec_cmd({OPC_SPARE, 12'hFFF}));
    pending_cmds.push_back(host_cmd(mm8_pkg::HOST_REG_RD, 8'hF8, 8'hFF));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      repeat (PhaseItems) pending_cmds.push_back(rand_cmd());
      while (pending_cmds.size() > 0 || in_valid || expected_outcomes.size() > 0)
        @(negedge clk);
    end

    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_outcomes.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- mini_mips8_instruction_execute.f -----
+incdir+sv
sv/mm8_pkg.sv
sv/mm8_exe.sv
sv/mini_mips8_instruction_execute.sv
tb/mini_mips8_instruction_execute_tb.sv
